// ===== rtl/assert_macros.svh =====
// Concurrent assertion helpers, clocked on clk_i.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked outside reset only.
`define SWFR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Checked on every edge, reset included.
`define SWFR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/swfr_pkg.sv =====
package swfr_pkg;

  localparam int unsigned DEPTH_DEF = 64;
  localparam int unsigned KIND_W    = 3;
  localparam int unsigned VALUE_W   = 32;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned COUNT_W   = 7;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH   = 3'd0,
    KIND_POP    = 3'd1,
    KIND_CLEAR  = 3'd2,
    KIND_REMOVE = 3'd3,
    KIND_EVENS  = 3'd4,
    KIND_REV    = 3'd5
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP,
    S_CMP,
    S_REV,
    S_REV_WLO,
    S_REV_WHI,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic signed [VALUE_W-1:0] popped;
    status_e                   status;
    logic [COUNT_W-1:0]        count;
  } res_t;

endpackage

// ===== rtl/swfr_in_if.sv =====
interface swfr_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [swfr_pkg::KIND_W-1:0]          kind;
  logic signed [swfr_pkg::VALUE_W-1:0]  value;

  modport source (output valid, kind, value, input ready);
  modport sink   (input valid, kind, value, output ready);
endinterface

// ===== rtl/swfr_out_if.sv =====
interface swfr_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [swfr_pkg::VALUE_W-1:0]  popped;
  logic [swfr_pkg::STATUS_W-1:0]        status;
  logic [swfr_pkg::COUNT_W-1:0]         count;

  modport source (output valid, popped, status, count, input ready);
  modport sink   (input valid, popped, status, count, output ready);
endinterface

// ===== rtl/swfr_out_stage.sv =====
module swfr_out_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               res_valid_i,
  output logic               res_ready_o,
  input  swfr_pkg::res_t     res_i,
  swfr_out_if.source         out_o
);
  import swfr_pkg::*;

  logic valid_q, valid_d;
  res_t data_q;

  assign res_ready_o = !valid_q || out_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (out_o.ready) begin
      valid_d = 1'b0;
    end
    if (res_valid_i && res_ready_o) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Load a new result only when the slot is free or draining.
  always_ff @(posedge clk_i) begin
    if (res_valid_i && res_ready_o) begin
      data_q <= res_i;
    end
  end

  assign out_o.valid  = valid_q;
  assign out_o.popped = data_q.popped;
  assign out_o.status = data_q.status;
  assign out_o.count  = data_q.count;

endmodule

// ===== rtl/stack_with_filter_and_reverse.sv =====
// Channel | Dir | Payload                        | Handshake
// in_i    | in  | kind[2:0], value[31:0] signed  | valid/ready, one request
// out_o   | out | popped[31:0], status[1:0],     | valid/ready, one result
//         |     | count[6:0]                     | per request
//
// Push, clear and unused kinds go straight to the result; pop first does one memory read.
// Remove-value and remove-evens compact the stack in place, reading one entry
// per cycle and writing back kept entries, then drain the last write.
// Reverse swaps pairs, low slot written first: the memory has one write port.
// Reset clears fill, not memory; entries are never read at or above fill.
// A stalled output holds the result register; the next request is taken
// once the block has handed its result to that register.
`include "assert_macros.svh"

module stack_with_filter_and_reverse #(
  parameter int unsigned DEPTH = swfr_pkg::DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  swfr_in_if.sink    in_i,
  swfr_out_if.source out_o
);
  import swfr_pkg::*;

  localparam int unsigned FILL_W = $clog2(DEPTH + 1);
  localparam int unsigned ADDR_W = $clog2(DEPTH);

  logic signed [VALUE_W-1:0] mem [DEPTH];

  state_e                    state_q, state_d;
  logic [FILL_W-1:0]         fill_q, fill_d;
  logic [FILL_W-1:0]         ptr_a_q, ptr_a_d;
  logic [FILL_W-1:0]         ptr_b_q, ptr_b_d;
  logic                      rd_vld_q, rd_vld_d;
  logic                      keep_odd_q, keep_odd_d;
  logic signed [VALUE_W-1:0] match_q, match_d;
  logic signed [VALUE_W-1:0] popped_q, popped_d;
  status_e                   status_q, status_d;

  logic                      wr_en;
  logic [ADDR_W-1:0]         wr_addr;
  logic signed [VALUE_W-1:0] wr_data;
  logic                      rd_en_a, rd_en_b;
  logic [ADDR_W-1:0]         rd_addr_a, rd_addr_b;
  logic signed [VALUE_W-1:0] rdata_a_q, rdata_b_q;

  logic                      in_fire;
  logic                      res_valid, res_ready;
  res_t                      res;
  logic [FILL_W:0]           lo_next;
  logic                      keep;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign lo_next    = {1'b0, ptr_a_q} + (FILL_W + 1)'(1);
  assign keep       = keep_odd_q ? rdata_a_q[0] : (rdata_a_q != match_q);

  assign res.popped = popped_q;
  assign res.status = status_q;
  assign res.count  = COUNT_W'(fill_q);

  always_comb begin
    state_d    = state_q;
    fill_d     = fill_q;
    ptr_a_d    = ptr_a_q;
    ptr_b_d    = ptr_b_q;
    rd_vld_d   = rd_vld_q;
    keep_odd_d = keep_odd_q;
    match_d    = match_q;
    popped_d   = popped_q;
    status_d   = status_q;
    wr_en      = 1'b0;
    wr_addr    = fill_q[ADDR_W-1:0];
    wr_data    = in_i.value;
    rd_en_a    = 1'b0;
    rd_en_b    = 1'b0;
    rd_addr_a  = ptr_a_q[ADDR_W-1:0];
    rd_addr_b  = ptr_b_q[ADDR_W-1:0];
    res_valid  = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          popped_d = '0;
          status_d = ST_OK;
          ptr_a_d  = '0;
          ptr_b_d  = '0;
          rd_vld_d = 1'b0;
          state_d  = S_EMIT;
          case (in_i.kind)
            KIND_PUSH: begin
              if (fill_q == FILL_W'(DEPTH)) begin
                status_d = ST_FULL;
              end else begin
                wr_en  = 1'b1;
                fill_d = fill_q + FILL_W'(1);
              end
            end
            KIND_POP: begin
              if (fill_q == '0) begin
                status_d = ST_EMPTY;
              end else begin
                fill_d    = fill_q - FILL_W'(1);
                rd_en_a   = 1'b1;
                rd_addr_a = fill_d[ADDR_W-1:0];
                state_d   = S_POP;
              end
            end
            KIND_CLEAR: begin
              fill_d = '0;
            end
            KIND_REMOVE: begin
              keep_odd_d = 1'b0;
              match_d    = in_i.value;
              state_d    = S_CMP;
            end
            KIND_EVENS: begin
              keep_odd_d = 1'b1;
              state_d    = S_CMP;
            end
            KIND_REV: begin
              ptr_b_d = fill_q;
              state_d = S_REV;
            end
            default: ;
          endcase
        end
      end

      S_POP: begin
        popped_d = rdata_a_q;
        state_d  = S_EMIT;
      end

      // Read index runs ahead of the write index, so a read never sees a
      // slot already rewritten by this pass.
      S_CMP: begin
        if (ptr_a_q < fill_q) begin
          rd_en_a = 1'b1;
          ptr_a_d = ptr_a_q + FILL_W'(1);
        end
        rd_vld_d = rd_en_a;
        if (rd_vld_q && keep) begin
          wr_en   = 1'b1;
          wr_addr = ptr_b_q[ADDR_W-1:0];
          wr_data = rdata_a_q;
          ptr_b_d = ptr_b_q + FILL_W'(1);
        end
        if (!rd_en_a && !rd_vld_q) begin
          fill_d  = ptr_b_q;
          state_d = S_EMIT;
        end
      end

      S_REV: begin
        if ({1'b0, ptr_b_q} > lo_next) begin
          ptr_b_d   = ptr_b_q - FILL_W'(1);
          rd_en_a   = 1'b1;
          rd_en_b   = 1'b1;
          rd_addr_b = ptr_b_d[ADDR_W-1:0];
          state_d   = S_REV_WLO;
        end else begin
          state_d = S_EMIT;
        end
      end

      S_REV_WLO: begin
        wr_en   = 1'b1;
        wr_addr = ptr_a_q[ADDR_W-1:0];
        wr_data = rdata_b_q;
        state_d = S_REV_WHI;
      end

      S_REV_WHI: begin
        wr_en   = 1'b1;
        wr_addr = ptr_b_q[ADDR_W-1:0];
        wr_data = rdata_a_q;
        ptr_a_d = ptr_a_q + FILL_W'(1);
        state_d = S_REV;
      end

      S_EMIT: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      fill_q   <= '0;
      ptr_a_q  <= '0;
      ptr_b_q  <= '0;
      rd_vld_q <= 1'b0;
      status_q <= ST_OK;
    end else begin
      state_q  <= state_d;
      fill_q   <= fill_d;
      ptr_a_q  <= ptr_a_d;
      ptr_b_q  <= ptr_b_d;
      rd_vld_q <= rd_vld_d;
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    keep_odd_q <= keep_odd_d;
    match_q    <= match_d;
    popped_q   <= popped_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en_a) begin
      rdata_a_q <= mem[rd_addr_a];
    end
    if (rd_en_b) begin
      rdata_b_q <= mem[rd_addr_b];
    end
  end

  swfr_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_ready_o (res_ready),
    .res_i       (res),
    .out_o       (out_o)
  );

  `SWFR_ASSERT(a_fill_bound, fill_q <= FILL_W'(DEPTH), "fill above depth")

  `SWFR_ASSERT(a_cmp_order, state_q == S_CMP |-> ptr_b_q <= ptr_a_q,
               "compact write passed read")

  `SWFR_ASSERT(a_push_grow,
               in_fire && in_i.kind == KIND_PUSH && fill_q != FILL_W'(DEPTH)
               |=> fill_q == $past(fill_q) + FILL_W'(1),
               "push did not grow fill")

  `SWFR_ASSERT(a_empty_zero,
               out_o.valid && out_o.status == ST_EMPTY |-> out_o.popped == '0,
               "empty pop returned data")

endmodule
